[rtl/assert_macros.svh]
// Assertion macros shared by the parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed: %m");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition: %m");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[rtl/escp_pkg.sv]
// Shared types, byte codes and lookup tables for the printer stream parser.
// No dependencies; used by escp_core, escp_outbuf and the top level.
package escp_pkg;

    // Result kinds
    typedef enum logic [3:0] {
        KIND_TEXT     = 4'd0,
        KIND_NEWLINES = 4'd1,
        KIND_SPACES   = 4'd2,
        KIND_FORMFEED = 4'd3,
        KIND_CUT      = 4'd4,
        KIND_BACKSP   = 4'd5,
        KIND_COMMAND  = 4'd6,
        KIND_IMAGE    = 4'd7,
        KIND_UNKNOWN  = 4'd8,
        KIND_CONTROL  = 4'd9
    } t_kind;

    // Parse modes
    typedef enum logic [1:0] {
        MODE_TEXT    = 2'd0,
        MODE_CMD     = 2'd1,
        MODE_COLLECT = 2'd2
    } t_mode;

    // Bit-image phases
    typedef enum logic [1:0] {
        IMG_NONE  = 2'd0,
        IMG_COUNT = 2'd1,
        IMG_DATA  = 2'd2
    } t_img;

    // One result item
    typedef struct packed {
        t_kind        kind;
        logic [1:0]   text_len;
        logic [23:0]  text_bytes;
        logic [7:0]   repeat_res;
        logic         is_gs;
        logic [7:0]   code;
        logic [2:0]   pcount;
        logic [31:0]  params;
    } t_result;

    // All results caused by one input item, first in slot 0
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     slot;
    } t_bundle;

    // UTF-8 form of one character
    typedef struct packed {
        logic [1:0]  len;
        logic [23:0] bytes;
    } t_utf8;

    // Control bytes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_GS  = 8'h1D;

    // Command bytes with side effects
    localparam logic [7:0] CMD_INIT = 8'h40;  // ESC @
    localparam logic [7:0] CMD_FEED = 8'h64;  // ESC d n
    localparam logic [7:0] CMD_CUT  = 8'h56;  // GS V n

    // Parameter length codes
    localparam logic [2:0] LEN_ZERO = 3'd0;
    localparam logic [2:0] LEN_NUL  = 3'd4;
    localparam logic [2:0] LEN_IMG  = 3'd5;
    localparam logic [2:0] LEN_BAD  = 3'd6;

    // Code points for bytes 0x80 to 0xFF
    localparam logic [15:0] CP437_HI [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    // Convert one byte to UTF-8
    function automatic t_utf8 utf8_of(input logic [7:0] c);
        logic [15:0] u;
        t_utf8       r;
        u = c[7] ? CP437_HI[c[6:0]] : {8'h00, c};
        r = '0;
        if (u < 16'h0080) begin
            r.len   = 2'd1;
            r.bytes = {16'h0000, u[7:0]};
        end else if (u < 16'h0800) begin
            r.len   = 2'd2;
            r.bytes = {8'h00, 2'b10, u[5:0], 3'b110, u[10:6]};
        end else begin
            r.len   = 2'd3;
            r.bytes = {2'b10, u[5:0], 2'b10, u[11:6], 4'b1110, u[15:12]};
        end
        return r;
    endfunction

    // Parameter length after an ESC intro
    function automatic logic [2:0] esc_len(input logic [7:0] c);
        logic [2:0] len;
        case (c)
            8'h40, 8'h46, 8'h48, 8'h30, 8'h31, 8'h32, 8'h34, 8'h35,
            8'h36, 8'h37, 8'h38, 8'h39, 8'h3C, 8'h3D, 8'h3E: len = LEN_ZERO;
            8'h21, 8'h2D, 8'h33, 8'h41, 8'h43, 8'h4A, 8'h4E, 8'h51,
            8'h52, 8'h53, 8'h55, 8'h57, 8'h61, 8'h64, 8'h6C, 8'h72,
            8'h73, 8'h77, 8'h25, 8'h2F: len = 3'd1;
            8'h24, 8'h66: len = 3'd2;
            8'h3A: len = 3'd3;
            8'h44, 8'h42, 8'h62: len = LEN_NUL;
            8'h4B, 8'h4C, 8'h59, 8'h5A: len = LEN_IMG;
            default: len = LEN_BAD;
        endcase
        return len;
    endfunction

    // Parameter length after a GS intro
    function automatic logic [2:0] gs_len(input logic [7:0] c);
        logic [2:0] len;
        case (c)
            8'h56, 8'h21, 8'h42, 8'h68, 8'h77, 8'h66, 8'h72: len = 3'd1;
            8'h4C, 8'h57, 8'h48: len = 3'd2;
            default: len = LEN_BAD;
        endcase
        return len;
    endfunction

endpackage

[rtl/escp_printer_stream_parser.sv]
// Printer byte-stream parser, top level: input register, parser core, result register.
// Flow: a byte waits in the input register until its results can load the result register.
// Throughput: one byte per cycle while each byte yields at most one result and the output
//   is not stalled; the k results of a byte (k up to 3) hold the result register until taken.
// Reset: synchronous, active low; parser returns to text mode at column 0.
// Depends on escp_pkg, escp_core and escp_outbuf.

module escp_printer_stream_parser #(
    parameter int TAB_STOP    = 8,
    parameter int PARAM_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [1:0]  o_text_len,
    output logic [23:0] o_text_bytes,
    output logic [7:0]  o_repeat_res,
    output logic        o_cmd_is_gs,
    output logic [7:0]  o_cmd_code,
    output logic [2:0]  o_param_count,
    output logic [31:0] o_params,
    output logic        o_last
);

    logic              r_in_vld, n_in_vld;
    logic [7:0]        r_in_byte;
    logic              in_take;
    logic              fire;
    logic              room;
    escp_pkg::t_bundle bundle;
    escp_pkg::t_result res;

    // Process the held item once the result register can take its results
    always_comb begin
        fire       = r_in_vld && room;
        o_in_stall = r_in_vld && !fire;
        in_take    = i_in_valid && !o_in_stall;
        n_in_vld   = in_take ? 1'b1 : (fire ? 1'b0 : r_in_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
    end

    escp_core #(
        .TAB_STOP    (TAB_STOP),
        .PARAM_SLOTS (PARAM_SLOTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .o_bundle (bundle)
    );

    escp_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_bundle    (bundle),
        .i_out_stall (i_out_stall),
        .o_room      (room),
        .o_valid     (o_out_valid),
        .o_last      (o_last),
        .o_res       (res)
    );

    // Drive the result fields
    assign o_kind        = res.kind;
    assign o_text_len    = res.text_len;
    assign o_text_bytes  = res.text_bytes;
    assign o_repeat_res  = res.repeat_res;
    assign o_cmd_is_gs   = res.is_gs;
    assign o_cmd_code    = res.code;
    assign o_param_count = res.pcount;
    assign o_params      = res.params;

endmodule

[rtl/escp_core.sv]
// Parser state and per-item decode: turns one byte into up to three results.
// Depends on escp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module escp_core #(
    parameter int TAB_STOP    = 8,
    parameter int PARAM_SLOTS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output escp_pkg::t_bundle o_bundle
);

    localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int GOT_W = $clog2(PARAM_SLOTS + 1);
    localparam int IDX_W = $clog2(PARAM_SLOTS);
    localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(TAB_STOP - 1);
    localparam logic [PH_W-1:0]  PH_SAT   = PH_W'(255 % TAB_STOP);
    localparam logic [8:0]       TAB_W    = 9'(TAB_STOP);
    localparam logic [GOT_W-1:0] GOT_FULL = GOT_W'(PARAM_SLOTS);
    localparam logic [GOT_W-1:0] GOT_PACK = GOT_W'(4);

    // State registers
    escp_pkg::t_mode  r_mode, n_mode;
    escp_pkg::t_img   r_img, n_img;
    logic             r_gs, n_gs;
    logic [7:0]       r_cmd, n_cmd;
    logic [15:0]      r_want, n_want;
    logic             r_until_nul, n_until_nul;
    logic [7:0]       r_pstore [PARAM_SLOTS];
    logic [7:0]       n_pstore [PARAM_SLOTS];
    logic [GOT_W-1:0] r_got, n_got;
    logic [7:0]       r_col, n_col;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic             r_cr, n_cr;

    // Decode signals
    logic             cr_ev;
    logic [7:0]       col_a;
    logic [PH_W-1:0]  ph_a;
    logic [2:0]       len;
    logic [15:0]      want_d;
    logic             store_req;
    logic [7:0]       ps_st [PARAM_SLOTS];
    logic [GOT_W-1:0] got_st;
    logic [15:0]      img_count;
    logic             do_finish;
    logic             do_image_hdr;
    logic             do_unknown;
    logic [8:0]       tab_to;

    // Finish-command signals
    logic [GOT_W-1:0]  fin_got;
    logic [7:0]        fin_cmd;
    logic [2:0]        fin_pc;
    logic [31:0]       fin_packed;
    logic              fin_two;
    logic              fin_clr;
    escp_pkg::t_result fin_res0, fin_res1;

    // Result assembly
    escp_pkg::t_result main0, main1, nl_one;
    logic [1:0]        main_n;
    escp_pkg::t_utf8   utf;

    // Pending CR resolves first and clears the column
    always_comb begin
        cr_ev = r_cr && (i_byte != escp_pkg::CH_LF);
        col_a = cr_ev ? 8'd0 : r_col;
        ph_a  = cr_ev ? '0 : r_phase;
    end

    // Store one parameter byte while collecting
    always_comb begin
        store_req = 1'b0;
        if (r_mode != escp_pkg::MODE_TEXT && r_mode != escp_pkg::MODE_CMD) begin
            store_req = r_until_nul ? (i_byte != escp_pkg::CH_NUL)
                                    : (r_img != escp_pkg::IMG_DATA);
        end
        ps_st  = r_pstore;
        got_st = r_got;
        if (store_req && r_got < GOT_FULL) begin
            ps_st[r_got[IDX_W-1:0]] = i_byte;
            got_st = r_got + GOT_W'(1);
        end
        img_count = {ps_st[1], ps_st[0]};
    end

    // Classify the item
    always_comb begin
        len          = r_gs ? escp_pkg::gs_len(i_byte) : escp_pkg::esc_len(i_byte);
        want_d       = (r_want != 16'd0) ? r_want - 16'd1 : 16'd0;
        tab_to       = {1'b0, col_a} + TAB_W - 9'(ph_a);
        do_unknown   = 1'b0;
        do_image_hdr = 1'b0;
        do_finish    = 1'b0;
        case (r_mode)
            escp_pkg::MODE_TEXT: begin
            end
            escp_pkg::MODE_CMD: begin
                do_unknown = (len == escp_pkg::LEN_BAD);
                do_finish  = (len == escp_pkg::LEN_ZERO);
            end
            default: begin
                if (r_until_nul) begin
                    do_finish = (i_byte == escp_pkg::CH_NUL);
                end else if (want_d == 16'd0) begin
                    do_image_hdr = (r_img == escp_pkg::IMG_COUNT);
                    do_finish    = (r_img != escp_pkg::IMG_COUNT) &&
                                   (r_img != escp_pkg::IMG_DATA);
                end
            end
        endcase
    end

    // Build the command-complete event and its follow-up
    always_comb begin
        fin_got    = (r_mode == escp_pkg::MODE_CMD) ? '0 : got_st;
        fin_cmd    = (r_mode == escp_pkg::MODE_CMD) ? i_byte : r_cmd;
        fin_pc     = (fin_got < GOT_PACK) ? 3'(fin_got) : 3'd4;
        fin_packed = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < fin_pc) begin
                fin_packed[8*i +: 8] = ps_st[i];
            end
        end
        fin_res0        = '0;
        fin_res0.kind   = escp_pkg::KIND_COMMAND;
        fin_res0.is_gs  = r_gs;
        fin_res0.code   = fin_cmd;
        fin_res0.pcount = fin_pc;
        fin_res0.params = fin_packed;
        fin_res1        = '0;
        fin_two         = 1'b0;
        fin_clr         = 1'b0;
        if (!r_gs) begin
            if (fin_cmd == escp_pkg::CMD_INIT) begin
                fin_clr = 1'b1;
            end else if (fin_cmd == escp_pkg::CMD_FEED && fin_got != '0) begin
                fin_clr = 1'b1;
                if (ps_st[0] != 8'd0) begin
                    fin_two             = 1'b1;
                    fin_res1.kind       = escp_pkg::KIND_NEWLINES;
                    fin_res1.repeat_res = ps_st[0];
                end
            end
        end else if (fin_cmd == escp_pkg::CMD_CUT) begin
            fin_clr       = 1'b1;
            fin_two       = 1'b1;
            fin_res1.kind = escp_pkg::KIND_CUT;
        end
    end

    // Next state
    always_comb begin
        n_mode      = r_mode;
        n_img       = r_img;
        n_gs        = r_gs;
        n_cmd       = r_cmd;
        n_want      = r_want;
        n_until_nul = r_until_nul;
        n_pstore    = ps_st;
        n_got       = got_st;
        n_col       = col_a;
        n_phase     = ph_a;
        n_cr        = 1'b0;
        case (r_mode)
            escp_pkg::MODE_TEXT: begin
                case (i_byte)
                    escp_pkg::CH_ESC, escp_pkg::CH_GS: begin
                        n_gs        = (i_byte == escp_pkg::CH_GS);
                        n_mode      = escp_pkg::MODE_CMD;
                        n_until_nul = 1'b0;
                        n_img       = escp_pkg::IMG_NONE;
                    end
                    escp_pkg::CH_LF, escp_pkg::CH_FF: begin
                        n_col   = 8'd0;
                        n_phase = '0;
                    end
                    escp_pkg::CH_CR: begin
                        n_cr = 1'b1;
                    end
                    escp_pkg::CH_TAB: begin
                        if (tab_to > 9'd255) begin
                            n_col   = 8'd255;
                            n_phase = PH_SAT;
                        end else begin
                            n_col   = tab_to[7:0];
                            n_phase = '0;
                        end
                    end
                    escp_pkg::CH_BS: begin
                        if (col_a != 8'd0) begin
                            n_col   = col_a - 8'd1;
                            n_phase = (ph_a == '0) ? PH_LAST : ph_a - PH_W'(1);
                        end
                    end
                    escp_pkg::CH_NUL: begin
                    end
                    default: begin
                        // printable byte advances the column, saturating
                        if (!(i_byte inside {[8'h01:8'h1F]}) && col_a != 8'd255) begin
                            n_col   = col_a + 8'd1;
                            n_phase = (ph_a == PH_LAST) ? '0 : ph_a + PH_W'(1);
                        end
                    end
                endcase
            end
            escp_pkg::MODE_CMD: begin
                n_cmd = i_byte;
                n_got = '0;
                case (len)
                    escp_pkg::LEN_BAD: begin
                        n_mode = escp_pkg::MODE_TEXT;
                    end
                    escp_pkg::LEN_NUL: begin
                        n_until_nul = 1'b1;
                        n_mode      = escp_pkg::MODE_COLLECT;
                    end
                    escp_pkg::LEN_IMG: begin
                        n_img  = escp_pkg::IMG_COUNT;
                        n_want = 16'd2;
                        n_mode = escp_pkg::MODE_COLLECT;
                    end
                    default: begin
                        if (len != escp_pkg::LEN_ZERO) begin
                            n_want = 16'(len);
                            n_mode = escp_pkg::MODE_COLLECT;
                        end
                    end
                endcase
            end
            default: begin
                if (r_until_nul) begin
                    if (i_byte == escp_pkg::CH_NUL) begin
                        n_until_nul = 1'b0;
                    end
                end else begin
                    n_want = want_d;
                    if (want_d == 16'd0) begin
                        case (r_img)
                            escp_pkg::IMG_COUNT: begin
                                if (img_count != 16'd0) begin
                                    n_want = img_count;
                                    n_img  = escp_pkg::IMG_DATA;
                                end else begin
                                    n_img  = escp_pkg::IMG_NONE;
                                    n_mode = escp_pkg::MODE_TEXT;
                                end
                            end
                            escp_pkg::IMG_DATA: begin
                                n_img  = escp_pkg::IMG_NONE;
                                n_mode = escp_pkg::MODE_TEXT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        endcase
        // completed command returns to text
        if (do_finish) begin
            n_mode = escp_pkg::MODE_TEXT;
            if (fin_clr) begin
                n_col   = 8'd0;
                n_phase = '0;
            end
        end
    end

    // Result items
    always_comb begin
        utf               = escp_pkg::utf8_of(i_byte);
        nl_one            = '0;
        nl_one.kind       = escp_pkg::KIND_NEWLINES;
        nl_one.repeat_res = 8'd1;
        main0             = '0;
        main1             = '0;
        main_n            = 2'd0;
        if (r_mode == escp_pkg::MODE_TEXT) begin
            main_n = 2'd1;
            case (i_byte)
                escp_pkg::CH_LF: begin
                    main0 = nl_one;
                end
                escp_pkg::CH_FF: begin
                    main0.kind = escp_pkg::KIND_FORMFEED;
                end
                escp_pkg::CH_TAB: begin
                    main0.kind       = escp_pkg::KIND_SPACES;
                    main0.repeat_res = 8'(TAB_W - 9'(ph_a));
                end
                escp_pkg::CH_BS: begin
                    main0.kind = escp_pkg::KIND_BACKSP;
                end
                escp_pkg::CH_ESC, escp_pkg::CH_GS, escp_pkg::CH_CR, escp_pkg::CH_NUL: begin
                    main_n = 2'd0;
                end
                default: begin
                    if (i_byte inside {[8'h01:8'h1F]}) begin
                        main0.kind = escp_pkg::KIND_CONTROL;
                        main0.code = i_byte;
                    end else begin
                        main0.kind       = escp_pkg::KIND_TEXT;
                        main0.text_len   = utf.len;
                        main0.text_bytes = utf.bytes;
                    end
                end
            endcase
        end else if (do_unknown) begin
            main_n      = 2'd1;
            main0.kind  = escp_pkg::KIND_UNKNOWN;
            main0.is_gs = r_gs;
            main0.code  = i_byte;
        end else if (do_image_hdr) begin
            main_n       = 2'd1;
            main0.kind   = escp_pkg::KIND_IMAGE;
            main0.is_gs  = r_gs;
            main0.code   = r_cmd;
            main0.pcount = 3'd2;
            main0.params = {16'h0000, img_count};
        end else if (do_finish) begin
            main_n = fin_two ? 2'd2 : 2'd1;
            main0  = fin_res0;
            main1  = fin_res1;
        end
        // a lone CR goes out ahead of everything else
        if (cr_ev) begin
            o_bundle.cnt     = main_n + 2'd1;
            o_bundle.slot[0] = nl_one;
            o_bundle.slot[1] = main0;
            o_bundle.slot[2] = main1;
        end else begin
            o_bundle.cnt     = main_n;
            o_bundle.slot[0] = main0;
            o_bundle.slot[1] = main1;
            o_bundle.slot[2] = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= escp_pkg::MODE_TEXT;
            r_img       <= escp_pkg::IMG_NONE;
            r_gs        <= 1'b0;
            r_cmd       <= 8'd0;
            r_want      <= 16'd0;
            r_until_nul <= 1'b0;
            r_got       <= '0;
            r_col       <= 8'd0;
            r_phase     <= '0;
            r_cr        <= 1'b0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_img       <= n_img;
            r_gs        <= n_gs;
            r_cmd       <= n_cmd;
            r_want      <= n_want;
            r_until_nul <= n_until_nul;
            r_got       <= n_got;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_cr        <= n_cr;
        end
    end

    // Parameter bytes, undefined until written
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_pstore <= n_pstore;
        end
    end

    `ASSERT_IMPL(a_cr_only_text, i_clk, i_rst_n, r_cr |-> (r_mode == escp_pkg::MODE_TEXT))
    `ASSERT_IMPL(a_img_data_want, i_clk, i_rst_n, (r_img == escp_pkg::IMG_DATA) |-> (r_want != 16'd0 && r_mode == escp_pkg::MODE_COLLECT))

endmodule

[rtl/escp_outbuf.sv]
// Result register: holds the results of one item and hands them out one per cycle unless stalled.
// Depends on escp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module escp_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  escp_pkg::t_bundle i_bundle,
    input  logic              i_out_stall,
    output logic              o_room,
    output logic              o_valid,
    output logic              o_last,
    output escp_pkg::t_result o_res
);

    logic [1:0]        r_cnt, n_cnt;
    escp_pkg::t_result r_slot [3];
    escp_pkg::t_result n_slot [3];
    logic              take;

    // Front slot is shown; the last remaining one closes the item
    always_comb begin
        take    = (r_cnt != 2'd0) && !i_out_stall;
        o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);
        o_valid = (r_cnt != 2'd0);
        o_last  = (r_cnt == 2'd1);
        o_res   = r_slot[0];
    end

    // Load a new item or advance the queue by one
    always_comb begin
        n_cnt  = r_cnt;
        n_slot = r_slot;
        if (i_load) begin
            n_cnt     = i_bundle.cnt;
            n_slot[0] = i_bundle.slot[0];
            n_slot[1] = i_bundle.slot[1];
            n_slot[2] = i_bundle.slot[2];
        end else if (take) begin
            n_cnt     = r_cnt - 2'd1;
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    `ASSERT_IMPL(a_load_has_room, i_clk, i_rst_n, i_load |-> o_room)
    `ASSERT_IMPL(a_shift_count, i_clk, i_rst_n, (take && r_cnt > 2'd1) |=> (r_cnt == $past(r_cnt) - 2'd1))

endmodule
